// ----- design/gzmf_pkg.sv -----
// ----------------------------------------------------------------------------
// gzmf_pkg: shared types and constants of the gzip member framing parser
// Request codes, status codes, queue entry, result and register types.
// ----------------------------------------------------------------------------
`default_nettype none

package gzmf_pkg;

    // request classes, set by the front part
    typedef enum logic [1:0] {
        OP_BYTE      = 2'd0,
        OP_INFL_END  = 2'd1,
        OP_END_INPUT = 2'd2,
        OP_NOP       = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_MAGIC     = 3'd1,
        ST_METHOD    = 3'd2,
        ST_FLAGS     = 3'd3,
        ST_OVERSIZE  = 3'd4,
        ST_UNEXP_END = 3'd5,
        ST_CLEAN_END = 3'd6
    } t_status;

    // input command codes
    localparam logic [1:0] CMD_BYTE      = 2'd0;
    localparam logic [1:0] CMD_INFL_END  = 2'd1;
    localparam logic [1:0] CMD_END_INPUT = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FLAG_MASK = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HDR_MAX   = 1'b1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [7:0]  FLAG_MASK_RST = 8'h33;
    localparam logic [15:0] HDR_MAX_RST   = 16'd32768;

    localparam logic [7:0]  MAGIC_0        = 8'h1F;
    localparam logic [7:0]  MAGIC_1        = 8'h8B;
    localparam logic [7:0]  METHOD_DEFLATE = 8'd8;
    localparam logic [7:0]  NAME_TERM      = 8'h00;
    localparam int unsigned FLAG_EXTRA_BIT = 2;
    localparam int unsigned FLAG_NAME_BIT  = 3;
    localparam logic [15:0] TRAILER_BYTES  = 16'd8;
    localparam logic [3:0]  HDR_LAST_BYTE  = 4'd9;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
    } t_qitem;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       member_start;
        t_status    status;
    } t_result;

    typedef struct packed {
        logic [7:0]  flag_mask;
        logic [15:0] hdr_max;
    } t_cfg;

endpackage

`default_nettype wire

// ----- design/gzmf_if.sv -----
// ----------------------------------------------------------------------------
// gzmf_in_if / gzmf_out_if: request and result channels
// Valid/ready channels carrying the input request and the result fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface gzmf_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface gzmf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       member_start;
    logic [2:0] status;

    modport source (output valid, output payload_byte, output payload_valid,
                    output member_start, output status, input ready);
    modport sink   (input valid, input payload_byte, input payload_valid,
                    input member_start, input status, output ready);
endinterface

`default_nettype wire

// ----- design/gzmf_front.sv -----
// ----------------------------------------------------------------------------
// gzmf_front: request intake
// Accepts requests, classifies the command and registers the entry for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module gzmf_front (
    input  wire             i_clk,
    input  wire             i_rst_n,
    gzmf_in_if.sink         i_in,
    output logic            o_push_valid,
    output gzmf_pkg::t_qitem o_push_item,
    input  wire             i_push_ready
);
    import gzmf_pkg::*;

    logic   r_valid;
    t_qitem r_item;
    t_qitem n_item;

    assign i_in.ready   = !r_valid || i_push_ready;
    assign o_push_valid = r_valid;
    assign o_push_item  = r_item;

    always_comb begin
        n_item.data = 8'h00;
        case (i_in.command)
            CMD_BYTE: begin
                n_item.op   = OP_BYTE;
                n_item.data = i_in.data_byte;
            end
            CMD_INFL_END:  n_item.op = OP_INFL_END;
            CMD_END_INPUT: n_item.op = OP_END_INPUT;
            default:       n_item.op = OP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

// ----- design/gzmf_queue.sv -----
// ----------------------------------------------------------------------------
// gzmf_queue: request queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module gzmf_queue #(
    parameter int unsigned DEPTH = gzmf_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push_valid,
    input  wire gzmf_pkg::t_qitem i_push_item,
    output logic                  o_push_ready,
    output logic                  o_pop_valid,
    output gzmf_pkg::t_qitem      o_pop_item,
    input  wire                   i_pop_ready
);
    import gzmf_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_qitem             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               push;
    logic               pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

`default_nettype wire

// ----- design/gzmf_back.sv -----
// ----------------------------------------------------------------------------
// gzmf_back: member framing sequencer
// Walks header, extra field, name, payload and trailer; registers each result.
// ----------------------------------------------------------------------------
`default_nettype none

module gzmf_back (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire gzmf_pkg::t_cfg   i_cfg,
    input  wire                   i_pop_valid,
    input  wire gzmf_pkg::t_qitem i_pop_item,
    output logic                  o_pop_ready,
    gzmf_out_if.source            o_out
);
    import gzmf_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_XLEN    = 3'd1,
        PH_EXTRA   = 3'd2,
        PH_NAME    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_TRAILER = 3'd5
    } t_phase;

    t_phase      r_phase,   n_phase;
    logic [3:0]  r_hbc,     n_hbc;
    logic [7:0]  r_flags,   n_flags;
    logic [1:0]  r_chk,     n_chk;
    logic [7:0]  r_len_lo,  n_len_lo;
    logic [15:0] r_skip,    n_skip;
    logic [16:0] r_hsize,   n_hsize;
    logic        r_seen,    n_seen;
    t_status     r_sticky,  n_sticky;
    logic        r_out_valid;
    t_result     r_out,     n_out;

    logic        pop;
    logic [16:0] hsize_inc;
    logic [15:0] xlen;
    logic [17:0] xlen_sum;
    logic [15:0] skip_dec;
    logic [7:0]  b;

    assign o_pop_ready = !r_out_valid || o_out.ready;
    assign pop         = i_pop_valid && o_pop_ready;
    assign b           = i_pop_item.data;
    assign hsize_inc   = r_hsize + 17'd1;
    assign xlen        = {b, r_len_lo};
    assign xlen_sum    = {1'b0, hsize_inc} + {2'b00, xlen};
    assign skip_dec    = (r_skip != '0) ? r_skip - 16'd1 : 16'd0;

    assign o_out.valid         = r_out_valid;
    assign o_out.payload_byte  = r_out.payload_byte;
    assign o_out.payload_valid = r_out.payload_valid;
    assign o_out.member_start  = r_out.member_start;
    assign o_out.status        = r_out.status;

    always_comb begin
        n_phase  = r_phase;
        n_hbc    = r_hbc;
        n_flags  = r_flags;
        n_chk    = r_chk;
        n_len_lo = r_len_lo;
        n_skip   = r_skip;
        n_hsize  = r_hsize;
        n_seen   = r_seen;
        n_sticky = r_sticky;
        n_out    = '{payload_byte: 8'h00, payload_valid: 1'b0,
                     member_start: 1'b0, status: ST_OK};

        if (r_sticky != ST_OK) begin
            n_out.status = r_sticky;
        end else begin
            case (i_pop_item.op)
                OP_INFL_END: begin
                    if (r_phase == PH_PAYLOAD) begin
                        n_phase = PH_TRAILER;
                        n_skip  = TRAILER_BYTES;
                    end
                end
                OP_END_INPUT: begin
                    if (r_phase == PH_HEADER && r_hbc == '0 && r_seen) begin
                        n_out.status = ST_CLEAN_END;
                    end else begin
                        n_out.status = ST_UNEXP_END;
                        n_sticky     = ST_UNEXP_END;
                    end
                end
                OP_BYTE: begin
                    case (r_phase)
                        PH_HEADER: begin
                            n_hsize = hsize_inc;
                            if (r_chk == '0) begin
                                if ((r_hbc == 4'd0 && b != MAGIC_0) ||
                                    (r_hbc == 4'd1 && b != MAGIC_1)) begin
                                    n_chk = 2'(ST_MAGIC);
                                end else if (r_hbc == 4'd2 && b != METHOD_DEFLATE) begin
                                    n_chk = 2'(ST_METHOD);
                                end else if (r_hbc == 4'd3 &&
                                             (b & i_cfg.flag_mask) != 8'h00) begin
                                    n_chk = 2'(ST_FLAGS);
                                end
                            end
                            if (r_hbc == 4'd3) begin
                                n_flags = b;
                            end
                            if (r_hbc >= HDR_LAST_BYTE) begin
                                n_hbc = '0;
                                // checks run on the last fixed byte, so use the update
                                if (n_chk != '0) begin
                                    n_out.status = t_status'({1'b0, n_chk});
                                    n_sticky     = t_status'({1'b0, n_chk});
                                end else if (n_flags[FLAG_EXTRA_BIT]) begin
                                    n_phase = PH_XLEN;
                                end else if (n_flags[FLAG_NAME_BIT]) begin
                                    n_phase = PH_NAME;
                                end else begin
                                    n_phase            = PH_PAYLOAD;
                                    n_seen             = 1'b1;
                                    n_out.member_start = 1'b1;
                                end
                            end else begin
                                n_hbc = r_hbc + 4'd1;
                            end
                        end
                        PH_XLEN: begin
                            n_hsize = hsize_inc;
                            if (r_hbc == '0) begin
                                n_len_lo = b;
                                n_hbc    = 4'd1;
                            end else begin
                                n_hbc = '0;
                                if (xlen_sum >= {2'b00, i_cfg.hdr_max}) begin
                                    n_out.status = ST_OVERSIZE;
                                    n_sticky     = ST_OVERSIZE;
                                end else if (xlen == '0) begin
                                    if (r_flags[FLAG_NAME_BIT]) begin
                                        n_phase = PH_NAME;
                                    end else begin
                                        n_phase            = PH_PAYLOAD;
                                        n_seen             = 1'b1;
                                        n_out.member_start = 1'b1;
                                    end
                                end else begin
                                    n_skip  = xlen;
                                    n_phase = PH_EXTRA;
                                end
                            end
                        end
                        PH_EXTRA: begin
                            n_hsize = hsize_inc;
                            n_skip  = skip_dec;
                            if (skip_dec == '0) begin
                                if (r_flags[FLAG_NAME_BIT]) begin
                                    n_phase = PH_NAME;
                                end else begin
                                    n_phase            = PH_PAYLOAD;
                                    n_seen             = 1'b1;
                                    n_out.member_start = 1'b1;
                                end
                            end
                        end
                        PH_NAME: begin
                            n_hsize = hsize_inc;
                            if (hsize_inc >= {1'b0, i_cfg.hdr_max}) begin
                                n_out.status = ST_OVERSIZE;
                                n_sticky     = ST_OVERSIZE;
                            end else if (b == NAME_TERM) begin
                                n_phase            = PH_PAYLOAD;
                                n_seen             = 1'b1;
                                n_out.member_start = 1'b1;
                            end
                        end
                        PH_PAYLOAD: begin
                            n_out.payload_byte  = b;
                            n_out.payload_valid = 1'b1;
                        end
                        PH_TRAILER: begin
                            n_skip = skip_dec;
                            if (skip_dec == '0) begin
                                // trailer bytes count toward the next header
                                n_phase = PH_HEADER;
                                n_hbc   = '0;
                                n_chk   = '0;
                                n_hsize = {1'b0, TRAILER_BYTES};
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_hbc       <= '0;
            r_flags     <= '0;
            r_chk       <= '0;
            r_len_lo    <= '0;
            r_skip      <= '0;
            r_hsize     <= '0;
            r_seen      <= 1'b0;
            r_sticky    <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop_ready) begin
                r_out_valid <= i_pop_valid;
            end
            if (pop) begin
                r_phase  <= n_phase;
                r_hbc    <= n_hbc;
                r_flags  <= n_flags;
                r_chk    <= n_chk;
                r_len_lo <= n_len_lo;
                r_skip   <= n_skip;
                r_hsize  <= n_hsize;
                r_seen   <= n_seen;
                r_sticky <= n_sticky;
            end
        end
        if (pop) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    a_sticky_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sticky != ST_OK) |=> (r_sticky == $past(r_sticky)))
        else $error("sticky error changed");

    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.payload_valid) |->
            (r_out.status == ST_OK && !r_out.member_start))
        else $error("payload result carries status or member start");

    a_start_enters_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && n_out.member_start) |=> (r_phase == PH_PAYLOAD && r_seen))
        else $error("member start without entering payload");

    a_error_sets_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && n_out.status != ST_OK && n_out.status != ST_CLEAN_END) |=>
            (r_sticky == r_out.status))
        else $error("error result not latched");
`endif

endmodule

`default_nettype wire

// ----- design/gzip_member_framing_parser_top.sv -----
// ----------------------------------------------------------------------------
// gzip_member_framing_parser_top: gzip member framing parser
// Front intake, request queue and framing sequencer plus configuration registers.
// ----------------------------------------------------------------------------
// Throughput: one request per clock while the output is not stalled; each request gives one result.
// Path: an accepted request passes through the front register, the queue and
//   the result register before its result is presented.
// The queue lets intake continue while a finished result waits to be taken.
// Reset: synchronous, active low; clears all parse state, empties the queue
//   and loads the configuration registers with their reset values.
`default_nettype none

module gzip_member_framing_parser_top #(
    parameter int unsigned QUEUE_DEPTH = gzmf_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    gzmf_in_if.sink                           i_in,
    gzmf_out_if.source                        o_out,
    input  wire                               i_cfg_we,
    input  wire [gzmf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [gzmf_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import gzmf_pkg::*;

    t_cfg   r_cfg;
    logic   push_valid;
    t_qitem push_item;
    logic   push_ready;
    logic   pop_valid;
    t_qitem pop_item;
    logic   pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flag_mask <= FLAG_MASK_RST;
            r_cfg.hdr_max   <= HDR_MAX_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IDX_FLAG_MASK: r_cfg.flag_mask <= i_cfg_data[7:0];
                CFG_IDX_HDR_MAX:   r_cfg.hdr_max   <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    gzmf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .o_push_item  (push_item),
        .i_push_ready (push_ready)
    );

    gzmf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_item  (push_item),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_item   (pop_item),
        .i_pop_ready  (pop_ready)
    );

    gzmf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_pop_valid (pop_valid),
        .i_pop_item  (pop_item),
        .o_pop_ready (pop_ready),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire
